/* design/sgfb_pkg.sv */
`timescale 1ns / 1ps

package sgfb_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int GLYPH_ROWS    = 16;

	localparam int LINE_BYTES  = (SCREEN_WIDTH + 7) / 8;
	localparam int STORE_BYTES = LINE_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	// pixel coordinates: 11-bit origin plus up to (15*8+7)*15+14 of offset
	localparam int POS_W = 13;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic signed [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		MODE_DRAW = 2'd0,
		MODE_FILL = 2'd1,
		MODE_READ = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X = 2'd0,
		CFG_ORIGIN_Y = 2'd1,
		CFG_ZOOM     = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_FILL,
		ST_READ
	} state_t;

	localparam logic [7:0] BYTE_ONES = 8'hFF;

endpackage

/* design/sgfb_ifs.sv */
`timescale 1ns / 1ps

interface sgfb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [3:0]  char_slot;
	logic [3:0]  glyph_row;
	logic [7:0]  row_bits;
	logic        fill_value;
	logic [15:0] read_address;

	modport source (output valid, mode, char_slot, glyph_row, row_bits, fill_value,
		read_address, input ready);
	modport sink (input valid, mode, char_slot, glyph_row, row_bits, fill_value,
		read_address, output ready);
endinterface

interface sgfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

interface sgfb_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/sgfb_ram.sv */
`timescale 1ns / 1ps

module sgfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/scaled_glyph_framebuffer_blitter_core.sv */
`timescale 1ns / 1ps

// Glyph blitter over a 640x480 one-bit framebuffer held in a single
// simple dual-port RAM (one write, one registered read per cycle). Items are
// handled one at a time. A draw item walks its 8*zoom by zoom pixels in
// raster order, one pixel per cycle, each as a read-modify-write of its byte;
// off-screen pixels are still walked but are not written, and a zero zoom
// draws nothing. A fill item sweeps every byte through the write port, one
// per cycle. A read item waits only if the previous read_data has not yet
// been taken; an address beyond the store returns zero. Ignored items (mode
// three, glyph row out of range) are dropped without touching the store. The
// store has no reset: read a byte only after a fill or a draw has written it.
// Configuration writes are accepted on every cycle and should only be
// issued while the block is idle.
module scaled_glyph_framebuffer_blitter_core (
	input  logic clk,
	input  logic arst_n,
	sgfb_cfg_if.sink   cfg,
	sgfb_req_if.sink   req,
	sgfb_rsp_if.source rsp
);

	import sgfb_pkg::*;

	// configuration registers
	logic signed [10:0] origin_x_q;
	logic signed [10:0] origin_y_q;
	logic [3:0]         zoom_q;

	state_t state_q, state_d;

	// draw walker
	pos_t       x_q, y_q, xstart_q;
	logic [3:0] xz_q, yz_q;
	logic [2:0] k_q;
	logic [7:0] bits_q;

	// fill sweep
	addr_t fill_addr_q;
	logic  fill_val_q;

	// read
	logic       oob_q;
	logic       out_valid_q;
	logic [7:0] out_data_q;

	// read-modify-write stage and its forwarding register
	logic       valid_s1;
	addr_t      addr_s1;
	logic [2:0] bit_s1;
	logic       on_s1;
	logic       wr_valid_q;
	addr_t      wr_addr_q;
	logic [7:0] wr_data_q;

	// memory ports
	logic       ram_we, ram_re;
	addr_t      ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;

	logic       req_fire;
	logic       draw_ok;
	logic       on_screen;
	logic       last_pix;
	logic       read_done;
	addr_t      pix_addr;
	logic [3:0] zm1;
	logic [10:0] slot_off;
	logic [7:0]  row_off;
	logic [7:0]  rmw_base, rmw_byte, rmw_mask;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE) && !valid_s1;
	assign req_fire  = req.valid && req.ready;

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			zoom_q     <= 4'd1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				CFG_ORIGIN_X: origin_x_q <= cfg.data;
				CFG_ORIGIN_Y: origin_y_q <= cfg.data;
				CFG_ZOOM:     zoom_q     <= cfg.data[3:0];
				default:      ;
			endcase
		end
	end

	// a glyph row beyond the font height or a zero zoom draws nothing
	assign draw_ok = (32'(req.glyph_row) < GLYPH_ROWS) && (zoom_q != 4'd0);

	// square origins of the first glyph bit
	assign slot_off = 11'({req.char_slot, 3'b000}) * 11'(zoom_q);
	assign row_off  = 8'(req.glyph_row) * 8'(zoom_q);

	// raster walk: xz within the square, k the glyph bit, yz the row
	assign zm1      = zoom_q - 4'd1;
	assign last_pix = (xz_q == zm1) && (k_q == 3'd7) && (yz_q == zm1);

	assign on_screen = (x_q >= 0) && (x_q < POS_W'(SCREEN_WIDTH))
		&& (y_q >= 0) && (y_q < POS_W'(SCREEN_HEIGHT));
	assign pix_addr  = ADDR_W'(unsigned'(x_q) >> 3)
		+ ADDR_W'(unsigned'(y_q)) * ADDR_W'(LINE_BYTES);

	assign read_done = (state_q == ST_READ) && (!out_valid_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (mode_t'(req.mode))
						MODE_DRAW: state_d = draw_ok ? ST_DRAW : ST_IDLE;
						MODE_FILL: state_d = ST_FILL;
						MODE_READ: state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_DRAW: begin
				if (last_pix) begin
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				if (32'(fill_addr_q) == STORE_BYTES - 1) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (read_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// byte update with forwarding of the write issued alongside this read
	assign rmw_base = (wr_valid_q && (wr_addr_q == addr_s1)) ? wr_data_q : ram_rdata;
	assign rmw_mask = 8'd1 << bit_s1;
	assign rmw_byte = on_s1 ? (rmw_base | rmw_mask) : (rmw_base & ~rmw_mask);

	// memory port control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = pix_addr;
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = rmw_byte;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = ADDR_W'(req.read_address);
				ram_re    = req_fire && (mode_t'(req.mode) == MODE_READ)
					&& (32'(req.read_address) < STORE_BYTES);
			end
			ST_DRAW: begin
				ram_re = on_screen;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = fill_addr_q;
				ram_wdata = fill_val_q ? BYTE_ONES : 8'h00;
			end
			default: ;
		endcase
		if (valid_s1) begin
			ram_we = 1'b1;
		end
	end

	// walker, sweep and item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xz_q        <= '0;
			yz_q        <= '0;
			k_q         <= '0;
			fill_addr_q <= '0;
		end else if (req_fire) begin
			xz_q        <= '0;
			yz_q        <= '0;
			k_q         <= '0;
			fill_addr_q <= '0;
		end else if (state_q == ST_DRAW) begin
			if (xz_q == zm1) begin
				xz_q <= '0;
				k_q  <= k_q + 3'd1;
				if (k_q == 3'd7) begin
					yz_q <= yz_q + 4'd1;
				end
			end else begin
				xz_q <= xz_q + 4'd1;
			end
		end else if (state_q == ST_FILL) begin
			fill_addr_q <= fill_addr_q + addr_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			xstart_q   <= POS_W'(origin_x_q) + $signed({2'b00, slot_off});
			x_q        <= POS_W'(origin_x_q) + $signed({2'b00, slot_off});
			y_q        <= POS_W'(origin_y_q) + $signed({5'b00000, row_off});
			bits_q     <= req.row_bits;
			fill_val_q <= req.fill_value;
			oob_q      <= !(32'(req.read_address) < STORE_BYTES);
		end else if (state_q == ST_DRAW) begin
			if ((xz_q == zm1) && (k_q == 3'd7)) begin
				x_q <= xstart_q;
				y_q <= y_q + pos_t'(1);
			end else begin
				x_q <= x_q + pos_t'(1);
			end
		end
	end

	// read-modify-write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			valid_s1   <= (state_q == ST_DRAW) && on_screen;
			wr_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= pix_addr;
		bit_s1    <= x_q[2:0];
		on_s1     <= bits_q[k_q];
		wr_addr_q <= addr_s1;
		wr_data_q <= rmw_byte;
	end

	// result register, parts the read side from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (read_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_done) begin
			out_data_q <= oob_q ? 8'h00 : ram_rdata;
		end
	end

	sgfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// no memory write may disturb a pending read
	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !ram_we)
		else $error("frame store written during a read item");

	// the modify stage only ever follows a walker cycle
	a_s1_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == ST_DRAW))
		else $error("modify stage active outside a draw");

	// every write lands inside the store
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(ram_waddr) < STORE_BYTES))
		else $error("frame store write out of range");

	// no new item while the last pixel write is still in flight
	a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !req_fire)
		else $error("item taken while a pixel write is pending");

endmodule
